>>> rtl/core/mascon_pkg.sv
// shared types, op codes and constants for the masked ascon permutation
`timescale 1ns / 1ps

package mascon_pkg;

  localparam int unsigned WORD_COUNT = 5;
  localparam int unsigned TOTAL_ROUNDS = 12;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [3:0] LAST_ROUND = 4'(TOTAL_ROUNDS);

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  word_index;
    logic [63:0] load_share_a;
    logic [63:0] load_share_b;
    logic [63:0] refresh_0;
    logic [63:0] refresh_1;
    logic [63:0] refresh_2;
    logic [63:0] refresh_3;
    logic [63:0] refresh_4;
    logic [63:0] chi_random;
    logic [3:0]  start_round;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] read_share_a;
    logic [63:0] read_share_b;
  } out_beat_t;

  typedef struct packed {
    logic       load;
    logic       refresh;
    logic       round;
    logic [3:0] rnd;
    logic       capture;
    logic       read_sel;
  } ctl_cmd_t;

endpackage

>>> rtl/core/mascon_ctrl.sv
// sequencer for load, read and permutation runs of the masked ascon core
`timescale 1ns / 1ps

module mascon_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_op_i,
  input  logic [3:0]          in_start_round_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output mascon_pkg::ctl_cmd_t cmd_o
);
  import mascon_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic       state_q, state_d;
  logic [3:0] round_q, round_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic [3:0] start_rnd;
  ctl_cmd_t   cmd;

  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign accept = in_valid_i & ~in_stall_o;
  assign start_rnd = (in_start_round_i > LAST_ROUND) ? LAST_ROUND : in_start_round_i;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    cmd = '0;
    cmd.rnd = round_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op_i)
            OP_LOAD: begin
              cmd.load = 1'b1;
              cmd.capture = 1'b1;
            end
            OP_RUN: begin
              cmd.refresh = 1'b1;
              round_d = start_rnd;
              state_d = ST_RUN;
            end
            OP_READ: begin
              cmd.capture = 1'b1;
              cmd.read_sel = 1'b1;
            end
            default: begin
              cmd.capture = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (round_q >= LAST_ROUND) begin
          cmd.capture = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd.round = 1'b1;
          round_d = round_q + 4'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o = cmd;

endmodule

>>> rtl/core/mascon_dp.sv
// two-share state registers, masked round logic and result register
`timescale 1ns / 1ps

module mascon_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mascon_pkg::in_beat_t  in_beat_i,
  input  mascon_pkg::ctl_cmd_t  cmd_i,
  output mascon_pkg::out_beat_t out_beat_o
);
  import mascon_pkg::*;

  logic [63:0] a_q [WORD_COUNT];
  logic [63:0] b_q [WORD_COUNT];
  logic [63:0] mask_q;
  out_beat_t   out_q;

  logic [63:0] rf [WORD_COUNT];
  logic [63:0] x_a [WORD_COUNT];
  logic [63:0] x_b [WORD_COUNT];
  logic [63:0] z [WORD_COUNT];
  logic [63:0] c_a [WORD_COUNT];
  logic [63:0] c_b [WORD_COUNT];
  logic [63:0] l_a [WORD_COUNT];
  logic [63:0] l_b [WORD_COUNT];
  logic [63:0] n_a [WORD_COUNT];
  logic [63:0] n_b [WORD_COUNT];
  logic [63:0] mask_a_n, mask_b_n;
  logic [7:0]  rc;
  logic        idx_ok;

  function automatic logic [63:0] sigma(input logic [63:0] w, input logic [2:0] k);
    logic [63:0] r;
    unique case (k)
      3'd0: r = w ^ {w[18:0], w[63:19]} ^ {w[27:0], w[63:28]};
      3'd1: r = w ^ {w[60:0], w[63:61]} ^ {w[38:0], w[63:39]};
      3'd2: r = w ^ {w[0], w[63:1]} ^ {w[5:0], w[63:6]};
      3'd3: r = w ^ {w[9:0], w[63:10]} ^ {w[16:0], w[63:17]};
      3'd4: r = w ^ {w[6:0], w[63:7]} ^ {w[40:0], w[63:41]};
      default: r = w;
    endcase
    return r;
  endfunction

  assign rf[0] = in_beat_i.refresh_0;
  assign rf[1] = in_beat_i.refresh_1;
  assign rf[2] = in_beat_i.refresh_2;
  assign rf[3] = in_beat_i.refresh_3;
  assign rf[4] = in_beat_i.refresh_4;

  assign idx_ok = in_beat_i.word_index < 3'(WORD_COUNT);
  assign rc = {4'hF - cmd_i.rnd, cmd_i.rnd};

  // one masked round
  always_comb begin
    x_a[0] = a_q[0] ^ a_q[4];
    x_a[1] = a_q[1];
    x_a[2] = a_q[2] ^ {56'd0, rc} ^ a_q[1];
    x_a[3] = a_q[3];
    x_a[4] = a_q[4] ^ a_q[3];
    x_b[0] = b_q[0] ^ b_q[4];
    x_b[1] = b_q[1];
    x_b[2] = b_q[2] ^ b_q[1];
    x_b[3] = b_q[3];
    x_b[4] = b_q[4] ^ b_q[3];
    for (int k = 0; k < WORD_COUNT; k++) begin
      z[k] = x_a[k] ^ x_b[k];
    end

    mask_a_n = mask_q ^ (~x_a[0] & z[1]);
    mask_b_n = mask_q ^ (x_b[0] & z[1]);

    c_a[0] = x_a[0] ^ (~x_a[1] & z[2]);
    c_a[1] = x_a[1] ^ (~x_a[2] & z[3]);
    c_a[2] = x_a[2] ^ (~x_a[3] & z[4]);
    c_a[3] = x_a[3] ^ (~x_a[4] & z[0]);
    c_a[4] = x_a[4] ^ mask_a_n;
    c_b[0] = x_b[0] ^ (x_b[1] & z[2]);
    c_b[1] = x_b[1] ^ (x_b[2] & z[3]);
    c_b[2] = x_b[2] ^ (x_b[3] & z[4]);
    c_b[3] = x_b[3] ^ (x_b[4] & z[0]);
    c_b[4] = x_b[4] ^ mask_b_n;

    l_a[0] = c_a[0] ^ c_a[4];
    l_a[1] = c_a[1] ^ c_a[0];
    l_a[2] = ~c_a[2];
    l_a[3] = c_a[3] ^ c_a[2];
    l_a[4] = c_a[4];
    l_b[0] = c_b[0] ^ c_b[4];
    l_b[1] = c_b[1] ^ c_b[0];
    l_b[2] = c_b[2];
    l_b[3] = c_b[3] ^ c_b[2];
    l_b[4] = c_b[4];

    for (int k = 0; k < WORD_COUNT; k++) begin
      n_a[k] = sigma(l_a[k], 3'(k));
      n_b[k] = sigma(l_b[k], 3'(k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        a_q[k] <= '0;
        b_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      if (idx_ok) begin
        a_q[in_beat_i.word_index] <= in_beat_i.load_share_a;
        b_q[in_beat_i.word_index] <= in_beat_i.load_share_b;
      end
    end else if (cmd_i.refresh) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        a_q[k] <= a_q[k] ^ rf[k];
        b_q[k] <= b_q[k] ^ rf[k];
      end
    end else if (cmd_i.round) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        a_q[k] <= n_a[k];
        b_q[k] <= n_b[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.refresh) begin
      mask_q <= in_beat_i.chi_random;
    end else if (cmd_i.round) begin
      mask_q <= mask_a_n;
    end
    if (cmd_i.capture) begin
      if (cmd_i.read_sel && idx_ok) begin
        out_q.read_share_a <= a_q[in_beat_i.word_index];
        out_q.read_share_b <= b_q[in_beat_i.word_index];
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_beat_o = out_q;

endmodule

>>> rtl/core/masked_ascon_permutation.sv
// top level of the two-share masked ascon permutation core
// usage:
//   input channel in_valid_i / in_stall_o / in_beat_i carries one op per beat:
//   load a word pair, run the permutation, or read a word pair back.
//   every accepted beat yields exactly one beat on out_valid_o / out_stall_i /
//   out_beat_o; loads, runs and unused ops return zero shares.
// sequencing and throughput:
//   load and read: result registered in the cycle after the input beat.
//   run: a refresh step, then the rounds from start_round to 11 in turn on the
//   single masked round unit, then a step that posts the result (no rounds
//   are run when start_round is 12 or more).
//   a new beat is taken as soon as the core is idle and the result register
//   is free or being drained, so a run posts its result before the next beat
//   is taken; load/read sustain one item per cycle when the output drains.
// reset: asynchronous, active low; both share stores clear to zero and no
//   result is pending.
// stall: while out_stall_i holds a result, the result stays put and the
//   input side is stalled until the result beat is taken.
`timescale 1ns / 1ps

module masked_ascon_permutation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mascon_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mascon_pkg::out_beat_t out_beat_o
);
  import mascon_pkg::*;

  ctl_cmd_t cmd;

  mascon_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_op_i          (in_beat_i.op),
    .in_start_round_i (in_beat_i.start_round),
    .in_stall_o       (in_stall_o),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .cmd_o            (cmd)
  );

  mascon_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_beat_i  (in_beat_i),
    .cmd_i      (cmd),
    .out_beat_o (out_beat_o)
  );

endmodule
